>>> hdl/humidity_sensor_frame_decoder_unit_defines.svh
// Assertion helpers for the sensor frame decoder checker.
// Both expect clk_i and rst_ni in scope.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_UNIT_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_UNIT_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define HSFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Condition must hold in the cycle after the trigger.
`define HSFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/hsfd_pkg.sv
`default_nettype none

package hsfd_pkg;

  // Position of a byte inside the six-byte response frame.
  typedef enum logic [2:0] {
    PosTempMsb = 3'd0,
    PosTempLsb = 3'd1,
    PosTempCrc = 3'd2,
    PosHumMsb  = 3'd3,
    PosHumLsb  = 3'd4,
    PosHumCrc  = 3'd5
  } byte_pos_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusTempCrc = 2'd1,
    StatusHumCrc  = 2'd2
  } status_e;

  localparam logic [7:0]  CrcPoly    = 8'h31;
  localparam logic [7:0]  CrcInit    = 8'hFF;

  localparam int unsigned TempScale  = 17500;
  localparam int unsigned HumScale   = 12500;
  localparam int unsigned RoundBias  = 32767;
  localparam int unsigned Divisor    = 65535;
  localparam int unsigned TempOffset = 4500;
  localparam int unsigned HumOffset  = 600;
  localparam int unsigned HumMax     = 10000;

  localparam int unsigned TempProdW  = 31;
  localparam int unsigned HumProdW   = 30;

  // CRC-8, MSB first, one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // round(prod / 65535): split at bit 16, since x = q1*65535 + (q1 + lo),
  // and q1 + lo stays below twice the divisor, so one correction suffices.
  function automatic logic [14:0] div_round(input logic [TempProdW-1:0] prod);
    logic [TempProdW-1:0] x;
    logic [14:0]          q1;
    logic [16:0]          r1;
    x  = prod + TempProdW'(RoundBias);
    q1 = x[TempProdW-1:16];
    r1 = {1'b0, x[15:0]} + {2'b00, q1};
    return q1 + 15'(r1 >= 17'(Divisor));
  endfunction

endpackage

`default_nettype wire

>>> hdl/humidity_sensor_frame_decoder_unit.sv
// A result beat is offered on m_axis once the sixth byte has passed the stage 1 and stage 2 output registers.
// Throughput: one byte per cycle sustained, set by the byte CRC update;
//   a stall on m_axis backs up into s_axis only once both result registers are full.
// Reset (rst_ni low, asynchronous): frame position to the first byte, CRC to 0xFF,
//   temperature check flag and all valid flags cleared; word registers are not reset.
`default_nettype none

module humidity_sensor_frame_decoder_unit
  import hsfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input byte stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] frame_start
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi,
                                           // [31:29] zero
  output      logic [1:0]  m_axis_tuser    // [1:0] status
);

  // ---------------------------------------------------------------------------
  // Frame tracking state
  // ---------------------------------------------------------------------------
  byte_pos_e   pos_q, pos_d, pos_cur;
  logic [7:0]  crc_q, crc_d;
  logic        tok_q, tok_d;          // temperature CRC matched
  logic [15:0] tword_q, tword_d;
  logic [15:0] hword_q, hword_d;

  // Stage 1: scaled products of a completed frame
  logic                 s1_v_q, s1_v_d;
  logic [TempProdW-1:0] s1_tprod_q;
  logic [HumProdW-1:0]  s1_hprod_q;
  status_e              s1_status_q, status_new;

  // Stage 2: output register
  logic        m_v_q, m_v_d;
  logic [14:0] m_temp_q, m_temp_d;
  logic [13:0] m_hum_q, m_hum_d;
  status_e     m_status_q;

  logic s_fire, frame_done, out_ready, s1_move;

  logic [7:0] rx_byte;
  logic       frame_start;

  assign rx_byte     = s_axis_tdata;
  assign frame_start = s_axis_tuser;

  assign out_ready     = !m_v_q || m_axis_tready;
  assign s1_move       = s1_v_q && out_ready;
  // The frame stage frees up in the same cycle it hands over to the output.
  assign s_axis_tready = !s1_v_q || out_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // A start flag, or a stale position, restarts the frame at this byte.
  assign pos_cur    = (frame_start || pos_q > PosHumCrc) ? PosTempMsb : pos_q;
  assign frame_done = s_fire && (pos_cur == PosHumCrc);

  // Next position
  always_comb begin
    pos_d = pos_q;
    if (s_fire) begin
      case (pos_cur)
        PosTempMsb: pos_d = PosTempLsb;
        PosTempLsb: pos_d = PosTempCrc;
        PosTempCrc: pos_d = PosHumMsb;
        PosHumMsb:  pos_d = PosHumLsb;
        PosHumLsb:  pos_d = PosHumCrc;
        PosHumCrc:  pos_d = PosTempMsb;
        default:    pos_d = PosTempMsb;
      endcase
    end
  end

  // CRC, word capture and check result per byte
  always_comb begin
    crc_d      = crc_q;
    tok_d      = tok_q;
    tword_d    = tword_q;
    hword_d    = hword_q;
    status_new = StatusOk;
    if (!tok_q) begin
      status_new = StatusTempCrc;   // temperature failure wins over humidity
    end else if (crc_q != rx_byte) begin
      status_new = StatusHumCrc;
    end
    if (s_fire) begin
      case (pos_cur)
        PosTempMsb: begin
          crc_d   = crc8_byte(CrcInit, rx_byte);
          tword_d = {rx_byte, tword_q[7:0]};
        end
        PosTempLsb: begin
          crc_d   = crc8_byte(crc_q, rx_byte);
          tword_d = {tword_q[15:8], rx_byte};
        end
        PosTempCrc: begin
          tok_d = (crc_q == rx_byte);
          crc_d = CrcInit;
        end
        PosHumMsb: begin
          crc_d   = crc8_byte(CrcInit, rx_byte);
          hword_d = {rx_byte, hword_q[7:0]};
        end
        PosHumLsb: begin
          crc_d   = crc8_byte(crc_q, rx_byte);
          hword_d = {hword_q[15:8], rx_byte};
        end
        PosHumCrc: begin
          crc_d = CrcInit;
          tok_d = 1'b0;
        end
        default: begin
          crc_d = crc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosTempMsb;
      crc_q <= CrcInit;
      tok_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tword_q <= tword_d;
    hword_q <= hword_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: both words are complete when the humidity CRC byte arrives,
  // so the constant multiplies run off the word registers.
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_v_d = s1_v_q;
    if (frame_done) begin
      s1_v_d = 1'b1;
    end else if (s1_move) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      s1_tprod_q  <= TempProdW'(tword_q) * TempProdW'(TempScale);
      s1_hprod_q  <= HumProdW'(hword_q) * HumProdW'(HumScale);
      s1_status_q <= status_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: divide by 65535 with rounding, offset, clamp, zero on error
  // ---------------------------------------------------------------------------
  logic [14:0]        t_quo, h_quo;
  logic signed [15:0] t_full;

  assign t_quo  = div_round(s1_tprod_q);
  assign h_quo  = div_round(TempProdW'(s1_hprod_q));
  assign t_full = $signed({1'b0, t_quo}) - $signed(16'(TempOffset));

  always_comb begin
    m_temp_d = t_full[14:0];
    if (h_quo < 15'(HumOffset)) begin
      m_hum_d = '0;
    end else if (h_quo > 15'(HumMax + HumOffset)) begin
      m_hum_d = 14'(HumMax);
    end else begin
      m_hum_d = 14'(h_quo - 15'(HumOffset));
    end
    if (s1_status_q != StatusOk) begin
      m_temp_d = '0;
      m_hum_d  = '0;
    end
  end

  always_comb begin
    m_v_d = m_v_q;
    if (s1_move) begin
      m_v_d = 1'b1;
    end else if (m_axis_tready) begin
      m_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else begin
      m_v_q <= m_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      m_temp_q   <= m_temp_d;
      m_hum_q    <= m_hum_d;
      m_status_q <= s1_status_q;
    end
  end

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tdata  = {3'b000, m_hum_q, m_temp_q};
  assign m_axis_tuser  = m_status_q;

endmodule

`default_nettype wire

>>> hdl/hsfd_checker.sv
`default_nettype none

`include "humidity_sensor_frame_decoder_unit_defines.svh"

module hsfd_checker
  import hsfd_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // A failed CRC reports zero values.
  `HSFD_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser != StatusOk,
    m_axis_tdata == 32'd0, "result values not zero on CRC error")

  // Known status code, humidity clamped, padding bits clear.
  `HSFD_ASSERT_NOW(a_result_range, m_axis_tvalid,
    m_axis_tuser <= StatusHumCrc && m_axis_tdata[28:15] <= 14'(HumMax)
    && m_axis_tdata[31:29] == 3'd0,
    "result beat out of range")

  // Input backpressure only while a result is waiting.
  `HSFD_ASSERT_NOW(a_ready_low, !s_axis_tready, m_axis_tvalid,
    "input stalled with empty output")

  // A stalled result beat holds.
  `HSFD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "stalled result beat changed")

  // A fresh result beat goes back to an input beat, registered through stage 1 and the output stage.
  `HSFD_ASSERT_NOW(a_beat_origin, m_axis_tvalid && !$past(m_axis_tvalid),
    $past(in_beat, 2), "result beat without a preceding input beat")

endmodule

bind humidity_sensor_frame_decoder_unit hsfd_checker u_hsfd_checker (.*);

`default_nettype wire

>>> test/tb_humidity_sensor_frame_decoder_unit.sv
`timescale 1ns / 100ps

module tb_humidity_sensor_frame_decoder_unit;
  import hsfd_pkg::*;

  localparam int QuietLimit = 4000;  // cycles without any beat before giving up
  localparam int RandomBeats = 1024;
  localparam int DirectedRows = 26;

  // decoded reading as carried on the result stream
  typedef struct packed {
    logic signed [14:0] temp_c;
    logic [13:0]        hum_c;
    status_e            status;
  } reading_t;

  // how a directed row gets its byte
  typedef enum logic [1:0] {
    CrcAsGiven,
    CrcGood,
    CrcCorrupt
  } crc_fill_e;

  typedef struct packed {
    logic [7:0] rx;
    logic       start;
    crc_fill_e  fill;
    logic       pinned;  // expectation typed in below instead of predicted
    reading_t   want;
  } row_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       start;
    logic       pinned;
    reading_t   want;
  } beat_t;

  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyHalf,
    ReadySparse,
    ReadyPeriodic
  } ready_mode_e;

  localparam reading_t NoPin       = '0;
  localparam reading_t ColdDry     = '{temp_c: -15'sd4500, hum_c: 14'd0, status: StatusOk};
  localparam reading_t HotWet      = '{temp_c: 15'sd13000, hum_c: 14'd10000, status: StatusOk};
  localparam reading_t TempCrcFail = '{temp_c: 15'sd0, hum_c: 14'd0, status: StatusTempCrc};
  localparam reading_t HumCrcFail  = '{temp_c: 15'sd0, hum_c: 14'd0, status: StatusHumCrc};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // expectation attached to the beat currently on s_axis
  logic        beat_pinned;
  reading_t    beat_want;

  beat_t       stim_q[$];
  reading_t    readings_q[$];
  row_t        directed_rows [DirectedRows];
  int          n_directed;
  int          fail_count = 0;
  int          quiet_cycles = 0;

  // predictor state
  byte_pos_e   frame_pos = PosTempMsb;
  logic [7:0]  crc_run = CrcInit;
  logic [15:0] temp_word;
  logic [15:0] hum_word;
  logic        temp_crc_ok = 1'b0;

  ready_mode_e ready_mode = ReadyAlways;
  int          ready_left = 0;

  humidity_sensor_frame_decoder_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    repeat (8) begin
      if (c[7]) c = (c << 1) ^ CrcPoly;
      else      c = c << 1;
    end
    return c;
  endfunction

  // round(span * raw / 65535), integer only
  function automatic int scaled_round(input logic [15:0] raw, input int unsigned span);
    longint unsigned p;
    p = longint'(span) * raw + RoundBias;
    return int'(p / Divisor);
  endfunction

  // one received byte through the frame decoder; made=1 when a reading comes out
  task automatic decode_byte(input logic [7:0] rx, input logic start,
                             output logic made, output reading_t r);
    int t;
    int h;
    made = 1'b0;
    r = '0;
    if (start) frame_pos = PosTempMsb;
    case (frame_pos)
      PosTempMsb: begin
        crc_run = crc8_step(CrcInit, rx);
        temp_word[15:8] = rx;
        frame_pos = PosTempLsb;
      end
      PosTempLsb: begin
        crc_run = crc8_step(crc_run, rx);
        temp_word[7:0] = rx;
        frame_pos = PosTempCrc;
      end
      PosTempCrc: begin
        temp_crc_ok = (crc_run == rx);
        crc_run = CrcInit;
        frame_pos = PosHumMsb;
      end
      PosHumMsb: begin
        crc_run = crc8_step(CrcInit, rx);
        hum_word[15:8] = rx;
        frame_pos = PosHumLsb;
      end
      PosHumLsb: begin
        crc_run = crc8_step(crc_run, rx);
        hum_word[7:0] = rx;
        frame_pos = PosHumCrc;
      end
      default: begin
        // humidity CRC byte closes the frame; temperature failure wins
        if (!temp_crc_ok)        r.status = StatusTempCrc;
        else if (crc_run != rx)  r.status = StatusHumCrc;
        else                     r.status = StatusOk;
        if (r.status == StatusOk) begin
          t = scaled_round(temp_word, TempScale) - int'(TempOffset);
          h = scaled_round(hum_word, HumScale) - int'(HumOffset);
          if (h < 0) h = 0;
          if (h > int'(HumMax)) h = HumMax;
          r.temp_c = t[14:0];
          r.hum_c = h[13:0];
        end
        made = 1'b1;
        crc_run = CrcInit;
        temp_crc_ok = 1'b0;
        frame_pos = PosTempMsb;
      end
    endcase
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(3000, 3300));    // around the low humidity clamp
      3:       return 16'($urandom_range(55400, 55800));  // around the high humidity clamp
      default: return 16'($urandom);
    endcase
  endfunction

  // first len bytes of a response frame, CRCs good unless told otherwise
  task automatic queue_frame(input logic [15:0] tw, input logic [15:0] hw, input logic tbad,
                             input logic hbad, input logic start, input int len);
    logic [7:0] fb [6];
    logic [7:0] tc;
    logic [7:0] hc;
    beat_t      b;
    tc = crc8_step(crc8_step(CrcInit, tw[15:8]), tw[7:0]);
    hc = crc8_step(crc8_step(CrcInit, hw[15:8]), hw[7:0]);
    fb[0] = tw[15:8];
    fb[1] = tw[7:0];
    fb[2] = tbad ? tc ^ 8'($urandom_range(1, 255)) : tc;
    fb[3] = hw[15:8];
    fb[4] = hw[7:0];
    fb[5] = hbad ? hc ^ 8'($urandom_range(1, 255)) : hc;
    for (int k = 0; k < len; k++) begin
      b = '0;
      b.rx = fb[k];
      b.start = start && (k == 0);
      stim_q.push_back(b);
    end
  endtask

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // receiver: tready pattern switches at random between always, half, sparse and periodic modes
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_left <= $urandom_range(32, 256);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      ReadyAlways: m_axis_tready <= 1'b1;
      ReadyHalf:   m_axis_tready <= ($urandom_range(0, 1) == 1);
      ReadySparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:     m_axis_tready <= ((ready_left % 8) < 3);
    endcase
  end

  always @(posedge clk_i) begin : scoreboard
    logic     made;
    reading_t predicted;
    reading_t got;
    reading_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tuser, made, predicted);
        if (made) readings_q.push_back(beat_pinned ? beat_want : predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.temp_c = m_axis_tdata[14:0];
        got.hum_c = m_axis_tdata[28:15];
        got.status = status_e'(m_axis_tuser);
        if (readings_q.size() == 0) begin
          log_failure("result beat with nothing pending");
        end else begin
          want = readings_q.pop_front();
          if (got.temp_c !== want.temp_c)
            log_failure($sformatf("temperature_centi expected %0d, got %0d",
                                  want.temp_c, got.temp_c));
          if (got.hum_c !== want.hum_c)
            log_failure($sformatf("humidity_centi expected %0d, got %0d",
                                  want.hum_c, got.hum_c));
          if (got.status !== want.status)
            log_failure($sformatf("status expected %0d, got %0d", want.status, got.status));
          if (m_axis_tdata[31:29] !== 3'b000)
            log_failure($sformatf("tdata padding expected 0, got %0b", m_axis_tdata[31:29]));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    row_t       row;
    beat_t      b;
    logic [7:0] prev_hi;
    logic [7:0] prev_lo;
    logic [7:0] good;
    logic       resync;
    logic       drain;
    int         pick;
    int         len;
    int         idx;
    int         stop;
    int         gap;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tuser = 1'b0;
    beat_pinned = 1'b0;
    beat_want = '0;

    directed_rows = '{
      // partial frame, then dropped by a new frame start
      '{8'hAB, 1'b1, CrcAsGiven, 1'b0, NoPin},
      '{8'hCD, 1'b0, CrcAsGiven, 1'b0, NoPin},
      // all-zero words: coldest reading, humidity clamped low
      '{8'h00, 1'b1, CrcAsGiven, 1'b0, NoPin},
      '{8'h00, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'h00, 1'b0, CrcGood,    1'b0, NoPin},
      '{8'h00, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'h00, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'h00, 1'b0, CrcGood,    1'b1, ColdDry},
      // all-ones words, no frame start: position wraps after a full frame
      '{8'hFF, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'hFF, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'h00, 1'b0, CrcGood,    1'b0, NoPin},
      '{8'hFF, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'hFF, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'h00, 1'b0, CrcGood,    1'b1, HotWet},
      // both CRCs wrong: temperature failure reported
      '{8'h12, 1'b1, CrcAsGiven, 1'b0, NoPin},
      '{8'h34, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'h00, 1'b0, CrcCorrupt, 1'b0, NoPin},
      '{8'h56, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'h78, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'h00, 1'b0, CrcCorrupt, 1'b1, TempCrcFail},
      // humidity CRC wrong only
      '{8'h66, 1'b1, CrcAsGiven, 1'b0, NoPin},
      '{8'h66, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'h00, 1'b0, CrcGood,    1'b0, NoPin},
      '{8'h80, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'h00, 1'b0, CrcAsGiven, 1'b0, NoPin},
      '{8'h00, 1'b0, CrcCorrupt, 1'b1, HumCrcFail}
    };

    // CRC rows cover the two bytes just before them
    prev_hi = 8'h00;
    prev_lo = 8'h00;
    for (int i = 0; i < DirectedRows; i++) begin
      row = directed_rows[i];
      good = crc8_step(crc8_step(CrcInit, prev_hi), prev_lo);
      b = '0;
      case (row.fill)
        CrcGood:    b.rx = good;
        CrcCorrupt: b.rx = good ^ 8'h5A;
        default:    b.rx = row.rx;
      endcase
      b.start = row.start;
      b.pinned = row.pinned;
      b.want = row.want;
      prev_hi = prev_lo;
      prev_lo = b.rx;
      stim_q.push_back(b);
    end
    n_directed = stim_q.size();

    // random: mostly whole frames, some cut short, a little noise
    resync = 1'b1;
    while (stim_q.size() < n_directed + RandomBeats) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          b = '0;
          b.rx = 8'($urandom);
          b.start = ($urandom_range(0, 3) == 0);
          stim_q.push_back(b);
        end
        resync = 1'b1;
      end else begin
        len = (pick == 1) ? $urandom_range(1, 5) : 6;
        queue_frame(pick_word(), pick_word(), $urandom_range(0, 9) == 0,
                    $urandom_range(0, 9) == 0, resync || ($urandom_range(0, 1) == 1), len);
        resync = (len != 6);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bursts with gaps; drain fully after the directed rows and now and then
    idx = 0;
    while (idx < stim_q.size()) begin
      stop = idx + $urandom_range(1, 48);
      if (idx < n_directed && stop > n_directed) stop = n_directed;
      if (stop > stim_q.size()) stop = stim_q.size();
      while (idx < stop) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= stim_q[idx].rx;
        s_axis_tuser <= stim_q[idx].start;
        beat_pinned <= stim_q[idx].pinned;
        beat_want <= stim_q[idx].want;
        do @(posedge clk_i); while (!s_axis_tready);
        idx++;
      end
      drain = (idx == n_directed) || ($urandom_range(0, 39) == 0);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (drain && gap == 0) gap = 1;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'($urandom);
        s_axis_tuser <= 1'($urandom);
        repeat (gap) @(posedge clk_i);
        while (drain && readings_q.size() != 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (readings_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && readings_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
